### hw/rtl/colour_ramp_interpolator_core_macros.svh
// Assertion macros used by the checker file of the colour ramp core.
`ifndef COLOUR_RAMP_INTERPOLATOR_CORE_MACROS_SVH
`define COLOUR_RAMP_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define CRI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define CRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cramp_pkg.sv
// Types and constants shared by the colour ramp interpolator modules.
`timescale 1ns / 1ps
`default_nettype none
package cramp_pkg;
  localparam int MaxPoints = 6;
  localparam int KeyW      = 9;
  localparam int ChanW     = 8;
  localparam int PointW    = 33;
  localparam int CfgIdxW   = 3;
  localparam int DiffW     = 10;              // keys span at most 511
  localparam int RemW      = 19;              // 2 * 255 * 511 + 511 fits
  localparam int QBits     = 8;               // quotient never exceeds 255
  localparam int FifoDepth = 2;

  localparam logic [CfgIdxW-1:0] RegPointCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPoint0     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPoint5     = 3'd6;

  localparam logic signed [KeyW-1:0] KeyLow  = -9'sd255;
  localparam logic signed [KeyW-1:0] KeyHigh = 9'sd255;

  // One classified sample travelling from front to back.
  typedef struct packed {
    logic [DiffW-1:0]    num;   // sample minus lower key
    logic [DiffW-1:0]    den;   // upper key minus lower key
    logic [2:0][ChanW-1:0] lo;
    logic [2:0][ChanW-1:0] hi;
  } span_t;

  // Divider pipeline stage contents.
  typedef struct packed {
    logic [DiffW-1:0]      den;
    logic [2:0]            neg;
    logic [2:0][ChanW-1:0] lo;
    logic [2:0][ChanW-1:0] hi;
    logic [2:0][RemW-1:0]  rem;
    logic [2:0][QBits-1:0] quo;
  } div_t;
endpackage
`default_nettype wire

### hw/rtl/cramp_if.sv
// Handshake interfaces for the sample input and the colour output channels.
`timescale 1ns / 1ps
`default_nettype none
interface cramp_sample_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface cramp_colour_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

### hw/rtl/cramp_front.sv
// Front end: holds the ramp registers, clamps each sample and finds its span.
`timescale 1ns / 1ps
`default_nettype none
module cramp_front import cramp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [PointW-1:0]     cfg_data,
  input  wire logic signed [KeyW-1:0] sample,
  output span_t                      span
);
  logic [2:0]        point_count;
  logic [PointW-1:0] points [MaxPoints];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      for (int i = 0; i < MaxPoints; i++) points[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegPointCount) begin
        point_count <= cfg_data[2:0];
      end else if (cfg_index >= RegPoint0 && cfg_index <= RegPoint5) begin
        points[cfg_index - RegPoint0] <= cfg_data;
      end
    end
  end

  logic signed [KeyW:0]   v;
  logic signed [KeyW-1:0] lo_key, hi_key, pk;
  logic [2:0][ChanW-1:0]  lo_c, hi_c;
  logic signed [KeyW+1:0] num_w, den_w;

  always_comb begin
    v = (KeyW+1)'((sample < KeyLow) ? KeyLow : sample);
    lo_key = KeyLow;
    lo_c   = '0;
    hi_key = KeyHigh;
    hi_c   = '1;
    pk     = '0;
    for (int i = 0; i < MaxPoints; i++) begin
      pk = points[i][32:24];
      if (3'(i) < point_count && pk <= v) begin
        lo_key = pk;
        lo_c   = {points[i][7:0], points[i][15:8], points[i][23:16]};
      end
    end
    for (int i = MaxPoints - 1; i >= 0; i--) begin
      pk = points[i][32:24];
      if (3'(i) < point_count && pk >= v) begin
        hi_key = pk;
        hi_c   = {points[i][7:0], points[i][15:8], points[i][23:16]};
      end
    end
    num_w = (KeyW+2)'(v) - (KeyW+2)'(lo_key);
    den_w = (KeyW+2)'(hi_key) - (KeyW+2)'(lo_key);
    span.num = num_w[DiffW-1:0];
    span.den = den_w[DiffW-1:0];
    span.lo  = lo_c;
    span.hi  = hi_c;
  end
endmodule
`default_nettype wire

### hw/rtl/cramp_fifo.sv
// Two-entry queue between the front end and the divider back end.
`timescale 1ns / 1ps
`default_nettype none
module cramp_fifo import cramp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  span_t      push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output span_t      pop_data
);
  span_t mem [FifoDepth];
  logic  wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(FifoDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/cramp_back.sv
// Back end: multiplies, divides with rounding over eight stages, forms the colour.
`timescale 1ns / 1ps
`default_nettype none
module cramp_back import cramp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  span_t      in_data,
  output logic       in_take,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [ChanW-1:0] out_red,
  output logic [ChanW-1:0] out_green,
  output logic [ChanW-1:0] out_blue
);
  localparam int Stages = QBits + 1;

  logic  en;
  logic  vld [Stages];
  div_t  st  [Stages];
  div_t  st_next [Stages];

  // The whole pipe moves together; only a held output beat stops it.
  assign en      = !out_valid || out_ready;
  assign in_take = en && in_valid;

  // Stage 0: magnitude of num * (hi - lo), one 10x8 product per channel.
  always_comb begin
    logic [ChanW-1:0] mag;
    mag = '0;
    st_next[0].den = in_data.den;
    st_next[0].lo  = in_data.lo;
    st_next[0].hi  = in_data.hi;
    st_next[0].quo = '0;
    for (int c = 0; c < 3; c++) begin
      st_next[0].neg[c] = in_data.hi[c] < in_data.lo[c];
      mag = st_next[0].neg[c] ? in_data.lo[c] - in_data.hi[c]
                              : in_data.hi[c] - in_data.lo[c];
      st_next[0].rem[c] = RemW'(in_data.num) * RemW'(mag);
    end
  end

  // Restoring division of 2m + d by 2d, one quotient bit per stage.
  for (genvar j = 1; j < Stages; j++) begin : g_div
    always_comb begin
      logic [RemW-1:0] r, dv;
      st_next[j] = st[j-1];
      dv = RemW'({st[j-1].den, 1'b0}) << (QBits - j);
      for (int c = 0; c < 3; c++) begin
        r = (j == 1) ? RemW'({st[j-1].rem[c], 1'b0}) + RemW'(st[j-1].den)
                     : st[j-1].rem[c];
        if (r >= dv) begin
          st_next[j].rem[c] = r - dv;
          st_next[j].quo[c][QBits-j] = 1'b1;
        end else begin
          st_next[j].rem[c] = r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Stages; s++) st[s] <= st_next[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Stages; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < Stages; s++) vld[s] <= vld[s-1];
      out_valid <= vld[Stages-1];
    end
  end

  logic [2:0][ChanW-1:0] col;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (st[Stages-1].den == '0) begin
        col[c] = st[Stages-1].hi[c];
      end else if (st[Stages-1].neg[c]) begin
        col[c] = st[Stages-1].lo[c] - st[Stages-1].quo[c];
      end else begin
        col[c] = st[Stages-1].lo[c] + st[Stages-1].quo[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red   <= col[0];
      out_green <= col[1];
      out_blue  <= col[2];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/colour_ramp_interpolator_core.sv
// Top level of the colour ramp interpolator.
//   channel   dir  beat payload            handshake
//   in_ch     in   sample_value [8:0] s    valid/ready
//   out_ch    out  red, green, blue [7:0]  valid/ready
//   cfg       in   cfg_index, cfg_data     cfg_we, no back-pressure
// One sample is accepted per clock while the two-entry queue has room.
// A sample passes through the queue, the product stage, eight divider stages and the output register.
// The eight-stage restoring divider sets the latency; one beat per clock while not stalled.
// rst is synchronous and clears the ramp registers, queue and pipe valids.
// A held output beat stalls the back end; the front keeps taking beats until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module colour_ramp_interpolator_core import cramp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [PointW-1:0]  cfg_data,
  cramp_sample_if.sink            in_ch,
  cramp_colour_if.source          out_ch
);
  span_t span, q_data;
  logic  full, empty, take, push;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  cramp_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .sample (in_ch.sample_value),
    .span   (span)
  );

  cramp_fifo u_fifo (
    .clk, .rst,
    .push      (push),
    .push_data (span),
    .full      (full),
    .pop       (take),
    .empty     (empty),
    .pop_data  (q_data)
  );

  cramp_back u_back (
    .clk, .rst,
    .in_valid  (!empty),
    .in_data   (q_data),
    .in_take   (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.red),
    .out_green (out_ch.green),
    .out_blue  (out_ch.blue)
  );
endmodule
`default_nettype wire

### hw/rtl/cramp_checker.sv
// Port-level checker for the colour ramp interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "colour_ramp_interpolator_core_macros.svh"
module cramp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);
  logic [4:0] pending;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 5'(in_beat) - 5'(out_beat);
    end
  end

  `CRI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable({red, green, blue}), "output beat changed while stalled")
  `CRI_ASSERT_NOW(a_no_phantom, out_valid, pending != 5'd0, "output beat with no sample outstanding")
  `CRI_ASSERT_NOW(a_capacity, 1'b1, pending <= 5'd12, "more samples in flight than the pipe holds")
  `CRI_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid, "output valid right after reset")
endmodule

bind colour_ramp_interpolator_core cramp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);
`default_nettype wire
